// File: rtl/slt_pkg.sv
// Shared types and constants for the symbol label table.
package slt_pkg;

  localparam int NAME_W    = 64;
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 4;
  localparam int STATUS_W  = 3;
  localparam int IDX_OUT_W = 6;
  localparam int KIND_W    = 2;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_REVERSE = 2'd2;
  localparam logic [OP_W-1:0] OP_SECTION = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic [KIND_W-1:0] KIND_SECTION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CODE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
    logic              is_code;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic capture;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic can_issue;
    logic pend_hit;
    logic scan_end;
    logic out_ready;
  } dp_stat_t;

endpackage

// File: rtl/slt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/slt_dp.sv
// Datapath: command registers, label memory scan, compare and result register.
module slt_dp import slt_pkg::*; #(
  parameter int MAX_LABELS = 64,
  parameter int NAME_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data,
  input  logic [OP_W-1:0]       in_command,
  input  logic [NAME_W-1:0]     in_label_name,
  input  logic [LEN_W-1:0]      in_name_length,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  in_is_code,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IDX_OUT_W-1:0]  out_entry_index,
  output logic [ADDR_W-1:0]     out_found_address,
  output logic [KIND_W-1:0]     out_entry_kind,
  output logic [LEN_W-1:0]      out_found_name_length,
  output logic [NAME_W-1:0]     out_found_name
);

  localparam int CNT_W   = $clog2(MAX_LABELS + 1);
  localparam int IDX_W   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int ENTRY_W = $bits(entry_t);

  logic [ADDR_W-1:0] start_r;
  logic [ADDR_W-1:0] size_r;
  logic [CNT_W-1:0]  count_r;

  logic [OP_W-1:0]   op_r;
  logic [NAME_W-1:0] name_r;
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] addr_r;
  logic              code_r;
  logic              len_ok_r;

  logic [CNT_W-1:0]  rd_idx_r;
  logic              pend_r;
  logic [CNT_W-1:0]  pend_idx_r;
  logic              hit_r;
  logic [CNT_W-1:0]  hit_idx_r;
  entry_t            hit_entry_r;
  logic              out_valid_r;

  logic [NAME_W-1:0] in_mask;
  logic              in_len_ok;
  entry_t            rd_entry;
  logic [ENTRY_W-1:0] rd_bits;
  entry_t            new_entry;
  logic              name_match;
  logic              rev_match;
  logic              hit;
  logic              full;
  logic              create_ok;
  logic              wr_en;
  logic [ADDR_W:0]   sec_end;
  logic              in_sec;

  logic [STATUS_W-1:0] res_status;
  logic [CNT_W-1:0]    res_idx;
  logic [CNT_W+IDX_OUT_W-1:0] res_idx_wide;
  entry_t              res_entry;
  logic                res_show;
  logic [ADDR_W-1:0]   res_addr;
  logic [KIND_W-1:0]   res_kind;
  logic [LEN_W-1:0]    res_len;
  logic [NAME_W-1:0]   res_name;

  always_comb begin
    for (int b = 0; b < NAME_W / 8; b++) begin
      in_mask[b*8 +: 8] = (LEN_W'(b) < in_name_length) ? 8'hFF : 8'h00;
    end
  end

  assign in_len_ok = (in_name_length != '0) && (in_name_length <= LEN_W'(NAME_BYTES));

  slt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LABELS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (new_entry),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (rd_bits)
  );

  assign rd_entry = entry_t'(rd_bits);

  assign new_entry.addr    = addr_r | {{(ADDR_W-1){1'b0}}, code_r};
  assign new_entry.name    = name_r;
  assign new_entry.len     = len_r;
  assign new_entry.is_code = code_r;

  assign name_match = (rd_entry.len == len_r) && (rd_entry.name == name_r);
  assign rev_match  = rd_entry.is_code ? (rd_entry.addr[ADDR_W-1:1] == addr_r[ADDR_W-1:1])
                                       : (rd_entry.addr == addr_r);
  assign hit        = (op_r == OP_REVERSE) ? rev_match : name_match;

  assign full      = (count_r == CNT_W'(MAX_LABELS));
  assign create_ok = (op_r == OP_CREATE) && len_ok_r && !hit_r && !full;
  assign wr_en     = cmd.emit && create_ok;

  assign sec_end = {1'b0, start_r} + {1'b0, size_r};
  assign in_sec  = (addr_r >= start_r) && ({1'b0, addr_r} <= sec_end);

  assign stat.skip      = (op_r == OP_SECTION) || ((op_r != OP_REVERSE) && !len_ok_r);
  assign stat.can_issue = (rd_idx_r != count_r);
  assign stat.pend_hit  = pend_r && hit;
  assign stat.scan_end  = !pend_r && (rd_idx_r == count_r);
  assign stat.out_ready = !out_valid_r || !out_stall;

  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_entry  = '0;
    res_show   = 1'b0;
    res_addr   = '0;
    unique case (op_r)
      OP_CREATE: begin
        if (!len_ok_r) begin
          res_status = ST_BAD_LEN;
        end else if (hit_r) begin
          res_status = ST_DUP;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_idx   = count_r;
          res_entry = new_entry;
          res_show  = 1'b1;
        end
      end
      OP_LOOKUP, OP_REVERSE: begin
        if (hit_r) begin
          res_idx   = hit_idx_r;
          res_entry = hit_entry_r;
          res_show  = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_SECTION: begin
        if (in_sec) begin
          res_addr = start_r;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  assign res_idx_wide = {{IDX_OUT_W{1'b0}}, res_idx};
  assign res_kind = res_show ? (res_entry.is_code ? KIND_CODE : KIND_DATA) : KIND_SECTION;
  assign res_len  = res_show ? res_entry.len  : '0;
  assign res_name = res_show ? res_entry.name : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      size_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START: start_r <= cfg_data;
          CFG_SIZE:  size_r  <= cfg_data;
        endcase
      end
      if (wr_en) begin
        count_r <= count_r + CNT_W'(1);
      end
      pend_r <= cmd.issue;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (cmd.capture) begin
        hit_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_command;
      name_r   <= in_label_name & in_mask;
      len_r    <= in_name_length;
      addr_r   <= in_address;
      code_r   <= in_is_code;
      len_ok_r <= in_len_ok;
      rd_idx_r <= '0;
    end else if (cmd.issue) begin
      rd_idx_r <= rd_idx_r + CNT_W'(1);
    end
    if (cmd.issue) begin
      pend_idx_r <= rd_idx_r;
    end
    if (cmd.capture) begin
      hit_idx_r   <= pend_idx_r;
      hit_entry_r <= rd_entry;
    end
    if (cmd.emit) begin
      out_status            <= res_status;
      out_entry_index       <= res_idx_wide[IDX_OUT_W-1:0];
      out_found_address     <= res_show ? res_entry.addr : res_addr;
      out_entry_kind        <= res_kind;
      out_found_name_length <= res_len;
      out_found_name        <= res_name;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/slt_ctrl.sv
// Controller state machine that sequences load, memory scan and result.
module slt_ctrl import slt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.skip) begin
          state_nxt = S_DONE;
        end else if (stat.pend_hit) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DONE;
        end else if (stat.scan_end) begin
          state_nxt = S_DONE;
        end else if (stat.can_issue) begin
          cmd.issue = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/symbol_label_table_top.sv
// A transfer passes a load step, a scan that reads the stored labels one at a time from the
// label memory and stops at the first hit, and a result step; a new transfer is taken only when idle.
// Scan time is set by the single read port of the label memory; section lookups and bad
// lengths on create and lookup skip the scan.
// Reset is synchronous and active low: it clears the label count, both section registers,
// the controller state and the result valid; label memory contents are not cleared.
module symbol_label_table_top import slt_pkg::*; #(
  parameter int MAX_LABELS = 64,
  parameter int NAME_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_command,
  input  logic [NAME_W-1:0]    in_label_name,
  input  logic [LEN_W-1:0]     in_name_length,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic                 in_is_code,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [IDX_OUT_W-1:0] out_entry_index,
  output logic [ADDR_W-1:0]    out_found_address,
  output logic [KIND_W-1:0]    out_entry_kind,
  output logic [LEN_W-1:0]     out_found_name_length,
  output logic [NAME_W-1:0]    out_found_name
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  slt_dp #(
    .MAX_LABELS (MAX_LABELS),
    .NAME_BYTES (NAME_BYTES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_command            (in_command),
    .in_label_name         (in_label_name),
    .in_name_length        (in_name_length),
    .in_address            (in_address),
    .in_is_code            (in_is_code),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_entry_index       (out_entry_index),
    .out_found_address     (out_found_address),
    .out_entry_kind        (out_entry_kind),
    .out_found_name_length (out_found_name_length),
    .out_found_name        (out_found_name)
  );

endmodule

// File: rtl/slt_checker.sv
// Port-level assertion checker for the symbol label table, bound to the top level.
module slt_checker import slt_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [STATUS_W-1:0]  out_status,
  input logic [IDX_OUT_W-1:0] out_entry_index,
  input logic [ADDR_W-1:0]    out_found_address,
  input logic [KIND_W-1:0]    out_entry_kind,
  input logic [LEN_W-1:0]     out_found_name_length,
  input logic [NAME_W-1:0]    out_found_name
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_found_address) && $stable(out_found_name) && $stable(out_entry_index))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_entry_index == '0) &&
      (out_found_address == '0) && (out_entry_kind == KIND_SECTION) &&
      (out_found_name_length == '0) && (out_found_name == '0))
    else $error("failed result carries nonzero fields");

  a_section_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) && (out_entry_kind == KIND_SECTION) |->
      (out_entry_index == '0) && (out_found_name_length == '0) && (out_found_name == '0))
    else $error("section result carries label fields");

  a_code_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) && (out_entry_kind == KIND_CODE) |->
      out_found_address[0] && (out_found_name_length != '0))
    else $error("code label result without address bit 0 or name");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind symbol_label_table_top slt_checker u_slt_checker (.*);

// File: bench/symbol_label_table_top_test.sv
// Self-checking testbench for the symbol label table: directed table, then random phases.
module symbol_label_table_top_test;
  import slt_pkg::*;

  localparam int LABEL_SLOTS = 64;
  localparam int NAME_MAX = 8;
  localparam int RANDOM_PER_PHASE = 180;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OP_W-1:0]   cmd;
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic              is_code;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] index;
    logic [ADDR_W-1:0]    addr;
    logic [KIND_W-1:0]    kind;
    logic [LEN_W-1:0]     len;
    logic [NAME_W-1:0]    name;
  } answer_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    answer_t  want;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_command = OP_CREATE;
  logic [NAME_W-1:0]    in_label_name = '0;
  logic [LEN_W-1:0]     in_name_length = '0;
  logic [ADDR_W-1:0]    in_address = '0;
  logic                 in_is_code = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [IDX_OUT_W-1:0] out_entry_index;
  logic [ADDR_W-1:0]    out_found_address;
  logic [KIND_W-1:0]    out_entry_kind;
  logic [LEN_W-1:0]     out_found_name_length;
  logic [NAME_W-1:0]    out_found_name;

  // Predictor copy of the label table and the section registers.
  logic [ADDR_W-1:0] lbl_addr [LABEL_SLOTS];
  logic [NAME_W-1:0] lbl_name [LABEL_SLOTS];
  logic [LEN_W-1:0]  lbl_len [LABEL_SLOTS];
  logic              lbl_code [LABEL_SLOTS];
  int                label_total = 0;
  logic [ADDR_W-1:0] sect_start = '0;
  logic [ADDR_W-1:0] sect_size = '0;

  answer_t       expected_answers[$];
  directed_row_t directed_rows[$];
  bit            calm = 1'b0;
  int            error_count = 0;
  int            sent_count = 0;
  int            checked_count = 0;
  int            cycles = 0;
  int            status_seen [8];

  symbol_label_table_top #(
    .MAX_LABELS(LABEL_SLOTS),
    .NAME_BYTES(NAME_MAX)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_label_name(in_label_name),
    .in_name_length(in_name_length),
    .in_address(in_address),
    .in_is_code(in_is_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_entry_index(out_entry_index),
    .out_found_address(out_found_address),
    .out_entry_kind(out_entry_kind),
    .out_found_name_length(out_found_name_length),
    .out_found_name(out_found_name)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [NAME_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    if (len >= NAME_MAX) begin
      return '1;
    end
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  function automatic int find_label(input logic [NAME_W-1:0] name,
                                    input logic [LEN_W-1:0] len);
    if (len == 0 || len > NAME_MAX) begin
      return -1;
    end
    for (int i = 0; i < label_total; i++) begin
      if (lbl_len[i] == len && lbl_name[i] == (name & byte_mask(len))) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic answer_t fail_answer(input logic [STATUS_W-1:0] st);
    answer_t a;
    a = '0;
    a.status = st;
    return a;
  endfunction

  // Applies one request to the predicted table and returns its result.
  function automatic answer_t label_table_answer(input request_t rq);
    answer_t a;
    int slot;
    a = '0;
    slot = -1;
    case (rq.cmd)
      OP_CREATE: begin
        if (rq.len == 0 || rq.len > NAME_MAX) begin
          a.status = ST_BAD_LEN;
        end else if (find_label(rq.name, rq.len) >= 0) begin
          a.status = ST_DUP;
        end else if (label_total >= LABEL_SLOTS) begin
          a.status = ST_FULL;
        end else begin
          slot = label_total;
          lbl_addr[slot] = rq.is_code ? (rq.addr | 32'd1) : rq.addr;
          lbl_name[slot] = rq.name & byte_mask(rq.len);
          lbl_len[slot] = rq.len;
          lbl_code[slot] = rq.is_code;
          label_total++;
        end
      end
      OP_LOOKUP: begin
        slot = find_label(rq.name, rq.len);
        if (slot < 0) begin
          a.status = ST_NOT_FOUND;
        end
      end
      OP_REVERSE: begin
        for (int i = 0; i < label_total && slot < 0; i++) begin
          if (lbl_code[i] ? ((lbl_addr[i] | 32'd1) == rq.addr ||
                             (lbl_addr[i] & ~32'd1) == rq.addr)
                          : lbl_addr[i] == rq.addr) begin
            slot = i;
          end
        end
        if (slot < 0) begin
          a.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (rq.addr >= sect_start &&
            {1'b0, rq.addr} <= {1'b0, sect_start} + {1'b0, sect_size}) begin
          a.addr = sect_start;
          a.kind = KIND_SECTION;
        end else begin
          a.status = ST_NOT_FOUND;
        end
      end
    endcase
    if (slot >= 0) begin
      a.index = slot[IDX_OUT_W-1:0];
      a.addr = lbl_addr[slot];
      a.kind = lbl_code[slot] ? KIND_CODE : KIND_DATA;
      a.len = lbl_len[slot];
      a.name = lbl_name[slot];
    end
    return a;
  endfunction

  // Mostly well-formed traffic aimed at stored labels, with misses and bad lengths mixed in.
  function automatic request_t random_request();
    request_t rq;
    int pick;
    int k;
    logic [NAME_W-1:0] junk;
    pick = $urandom_range(0, 99);
    junk = {$urandom, $urandom};
    k = (label_total > 0) ? $urandom_range(0, label_total - 1) : 0;
    rq.cmd = OP_CREATE;
    rq.name = {$urandom, $urandom};
    rq.len = LEN_W'($urandom_range(1, NAME_MAX));
    rq.is_code = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: rq.addr = '0;
      1: rq.addr = '1;
      2, 3, 4: rq.addr = 32'h1000 + 2 * $urandom_range(0, 7) + $urandom_range(0, 1);
      default: rq.addr = $urandom;
    endcase
    if (pick < 15) begin
      rq.cmd = OP_CREATE;
    end else if (pick < 20 && label_total > 0) begin
      rq.name = lbl_name[k] | (junk & ~byte_mask(lbl_len[k]));
      rq.len = lbl_len[k];
    end else if (pick < 25) begin
      rq.len = ($urandom_range(0, 3) == 0) ? LEN_W'(0)
                                           : LEN_W'($urandom_range(NAME_MAX + 1, 15));
    end else if (pick < 50 && label_total > 0) begin
      rq.cmd = OP_LOOKUP;
      rq.name = lbl_name[k] | (junk & ~byte_mask(lbl_len[k]));
      rq.len = lbl_len[k];
    end else if (pick < 58) begin
      rq.cmd = OP_LOOKUP;
      rq.len = LEN_W'($urandom_range(0, 15));
    end else if (pick < 78 && label_total > 0) begin
      rq.cmd = OP_REVERSE;
      rq.addr = lbl_addr[k] ^ (($urandom_range(0, 9) < 3) ? 32'd1 : 32'd0);
    end else if (pick < 85) begin
      rq.cmd = OP_REVERSE;
    end else begin
      rq.cmd = OP_SECTION;
      case ($urandom_range(0, 5))
        0: rq.addr = sect_start - 32'd1;
        1: rq.addr = sect_start;
        2: rq.addr = sect_start + sect_size;
        3: rq.addr = sect_start + sect_size + 32'd1;
        4: rq.addr = sect_start + ($urandom & sect_size);
        default: rq.addr = $urandom;
      endcase
    end
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
    error_count++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] cmd, input logic [NAME_W-1:0] name,
                         input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] addr,
                         input logic code, input logic typed, input answer_t want);
    directed_row_t r;
    r.req = {cmd, name, len, addr, code};
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  task automatic send_request(input request_t rq, input logic typed, input answer_t want);
    answer_t predicted;
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= rq.cmd;
    in_label_name <= rq.name;
    in_name_length <= rq.len;
    in_address <= rq.addr;
    in_is_code <= rq.is_code;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = label_table_answer(rq);
    expected_answers.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic program_section(input logic [ADDR_W-1:0] start,
                                 input logic [ADDR_W-1:0] size);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START;
    cfg_data <= start;
    @(posedge clk);
    cfg_index <= CFG_SIZE;
    cfg_data <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    sect_start = start;
    sect_size = size;
  endtask

  always @(posedge clk) begin
    answer_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      if (rst_n && out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result with no request pending", 64'(out_status), '0);
        end else begin
          want = expected_answers.pop_front();
          checked_count++;
          status_seen[out_status]++;
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_entry_index !== want.index)
            report_mismatch("entry_index", 64'(out_entry_index), 64'(want.index));
          if (out_found_address !== want.addr)
            report_mismatch("found_address", 64'(out_found_address), 64'(want.addr));
          if (out_entry_kind !== want.kind)
            report_mismatch("entry_kind", 64'(out_entry_kind), 64'(want.kind));
          if (out_found_name_length !== want.len)
            report_mismatch("found_name_length", 64'(out_found_name_length),
                            64'(want.len));
          if (out_found_name !== want.name)
            report_mismatch("found_name", out_found_name, want.name);
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 29);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table with the section registers at their reset values.
    add_row(OP_SECTION, '1, 4'd0, 32'h0, 1'b1, 1'b1,
            {ST_OK, 6'd0, 32'h0, KIND_SECTION, 4'd0, 64'h0});
    add_row(OP_SECTION, '0, 4'd0, 32'h1, 1'b0, 1'b1, fail_answer(ST_NOT_FOUND));
    add_row(OP_SECTION, '0, 4'd0, '1, 1'b0, 1'b1, fail_answer(ST_NOT_FOUND));
    add_row(OP_LOOKUP, 64'h41, 4'd1, '0, 1'b0, 1'b1, fail_answer(ST_NOT_FOUND));
    add_row(OP_REVERSE, '0, 4'd1, '0, 1'b0, 1'b1, fail_answer(ST_NOT_FOUND));
    // Length checks come before anything else on create.
    add_row(OP_CREATE, '1, 4'd0, 32'h100, 1'b0, 1'b1, fail_answer(ST_BAD_LEN));
    add_row(OP_CREATE, 64'h41, 4'd9, 32'h100, 1'b1, 1'b1, fail_answer(ST_BAD_LEN));
    add_row(OP_CREATE, '1, 4'd15, '1, 1'b1, 1'b1, fail_answer(ST_BAD_LEN));
    add_row(OP_CREATE, 64'hFFFF_FFFF_FFFF_FF41, 4'd1, 32'h100, 1'b0, 1'b1,
            {ST_OK, 6'd0, 32'h100, KIND_DATA, 4'd1, 64'h41});
    add_row(OP_CREATE, '1, 4'd8, '1, 1'b1, 1'b1,
            {ST_OK, 6'd1, 32'hFFFF_FFFF, KIND_CODE, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF});
    add_row(OP_CREATE, 64'hDEAD_BEEF_0000_4241, 4'd2, 32'h200, 1'b1, 1'b0, '0);
    add_row(OP_CREATE, 64'h41, 4'd2, 32'h100, 1'b0, 1'b0, '0);
    add_row(OP_CREATE, 64'h5555_0000_0000_0041, 4'd1, 32'h0, 1'b0, 1'b1,
            fail_answer(ST_DUP));
    add_row(OP_CREATE, '0, 4'd8, 32'h0, 1'b0, 1'b0, '0);
    add_row(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AA41, 4'd1, '0, 1'b0, 1'b0, '0);
    add_row(OP_LOOKUP, 64'h41, 4'd2, '0, 1'b1, 1'b0, '0);
    add_row(OP_LOOKUP, 64'h41, 4'd0, '0, 1'b0, 1'b1, fail_answer(ST_NOT_FOUND));
    add_row(OP_LOOKUP, 64'h41, 4'd9, '0, 1'b0, 1'b1, fail_answer(ST_NOT_FOUND));
    add_row(OP_LOOKUP, '1, 4'd8, '0, 1'b0, 1'b0, '0);
    // Reverse lookups: oldest entry wins, code labels ignore address bit 0.
    add_row(OP_REVERSE, '0, 4'd0, 32'h100, 1'b0, 1'b0, '0);
    add_row(OP_REVERSE, '0, 4'd0, 32'h200, 1'b0, 1'b0, '0);
    add_row(OP_REVERSE, '0, 4'd0, 32'h201, 1'b0, 1'b0, '0);
    add_row(OP_REVERSE, '0, 4'd0, 32'h101, 1'b0, 1'b1, fail_answer(ST_NOT_FOUND));
    add_row(OP_REVERSE, '0, 4'd0, 32'hFFFF_FFFE, 1'b0, 1'b0, '0);
    add_row(OP_REVERSE, '1, 4'd15, 32'h0, 1'b1, 1'b0, '0);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // The table fills up during the random phases, so later phases see full rejections.
    for (int phase = 0; phase < 5; phase++) begin
      settle_block();
      case (phase)
        0: program_section(32'h0000_1000, 32'h0000_0100);
        1: program_section(32'hFFFF_FF00, 32'hFFFF_FFFF);
        2: program_section(32'h0000_0000, 32'hFFFF_FFFF);
        3: program_section(32'hFFFF_FFFF, 32'h0000_0000);
        default: program_section($urandom, $urandom_range(0, 4096));
      endcase
      calm = (phase == 2);
      repeat (RANDOM_PER_PHASE) begin
        send_request(random_request(), 1'b0, '0);
      end
    end

    settle_block();
    repeat (80) @(posedge clk);
    $display("summary: %0d transfers sent, %0d results checked, %0d labels stored",
             sent_count, checked_count, label_total);
    $display("summary: ok %0d, bad length %0d, duplicate %0d, full %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_BAD_LEN], status_seen[ST_DUP],
             status_seen[ST_FULL], status_seen[ST_NOT_FOUND]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: symbol_label_table_top.f
rtl/slt_pkg.sv
rtl/slt_ram.sv
rtl/slt_dp.sv
rtl/slt_ctrl.sv
rtl/symbol_label_table_top.sv
rtl/slt_checker.sv
bench/symbol_label_table_top_test.sv
